### sv/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge, off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, also during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/tlbc_pkg.sv
// Shared types, sizes and width helpers for the clock-replacement TLB.
// No dependencies; used by the interfaces, the cell, the top level and the checker.
package tlbc_pkg;

  localparam int ENTRIES     = 16;
  localparam int PAGE_BITS   = 20;
  localparam int FRAME_BITS  = 20;
  localparam int SLOT_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int IN_PAGE_W   = 20;
  localparam int IN_FRAME_W  = 20;
  localparam int OUT_FRAME_W = 20;
  localparam int OUT_SLOT_W  = 4;
  localparam int HIT_CNT_W   = 32;

  typedef logic [PAGE_BITS-1:0]   page_t;
  typedef logic [FRAME_BITS-1:0]  frame_t;
  typedef logic [SLOT_BITS-1:0]   slot_t;
  typedef logic [HIT_CNT_W-1:0]   hit_cnt_t;

  // Priority chain passed cell to cell: seen a match, an invalid entry,
  // an entry with its used bit clear.
  typedef struct packed {
    logic hit;
    logic free;
    logic clear;
  } chain_t;

  // Request broadcast to all cells.
  typedef struct packed {
    logic   go;
    logic   wr;
    page_t  page;
    frame_t frame;
  } req_t;

  function automatic page_t to_page(logic [IN_PAGE_W-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[PAGE_BITS-1:0];
  endfunction

  function automatic frame_t to_frame(logic [IN_FRAME_W-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[FRAME_BITS-1:0];
  endfunction

  function automatic logic [OUT_FRAME_W-1:0] frame_out(frame_t f);
    logic [63:0] w;
    w = 64'(f);
    return w[OUT_FRAME_W-1:0];
  endfunction

  function automatic logic [OUT_SLOT_W-1:0] slot_out(slot_t s);
    logic [31:0] w;
    w = 32'(s);
    return w[OUT_SLOT_W-1:0];
  endfunction

endpackage

### sv/tlbc_if.sv
// Valid/ready channel interfaces for lookup requests and results.
// Depends on tlbc_pkg for field widths.
interface tlbc_in_if;
  logic                               valid;
  logic                               ready;
  logic [tlbc_pkg::IN_PAGE_W-1:0]     page_number;
  logic                               is_write;
  logic [tlbc_pkg::IN_FRAME_W-1:0]    walked_frame;

  modport source (output valid, output page_number, output is_write,
                  output walked_frame, input ready);
  modport sink   (input valid, input page_number, input is_write,
                  input walked_frame, output ready);
endinterface

interface tlbc_out_if;
  logic                               valid;
  logic                               ready;
  logic [tlbc_pkg::OUT_FRAME_W-1:0]   frame_number;
  logic                               was_hit;
  logic [tlbc_pkg::OUT_SLOT_W-1:0]    slot_index;

  modport source (output valid, output frame_number, output was_hit,
                  output slot_index, input ready);
  modport sink   (input valid, input frame_number, input was_hit,
                  input slot_index, output ready);
endinterface

### sv/tlbc_cell.sv
// One TLB entry: tag, frame, valid/dirty/used bits and its link in the
// match / free / clock-sweep priority chain. Depends on tlbc_pkg.
module tlbc_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  tlbc_pkg::req_t   req,
  input  logic             first,
  input  tlbc_pkg::chain_t ci,
  input  tlbc_pkg::chain_t glb,
  output tlbc_pkg::chain_t co,
  output logic             hit_sel,
  output logic             victim_sel,
  output tlbc_pkg::frame_t frame
);

  tlbc_pkg::page_t  page_r,  page_nxt;
  tlbc_pkg::frame_t frame_r, frame_nxt;
  logic valid_r, valid_nxt;
  logic dirty_r, dirty_nxt;
  logic used_r,  used_nxt;
  logic match;
  logic sweep_clear;

  assign match   = valid_r && (page_r == req.page);
  assign co.hit   = ci.hit   | match;
  assign co.free  = ci.free  | !valid_r;
  assign co.clear = ci.clear | !used_r;

  assign hit_sel = match && !ci.hit;
  assign victim_sel = !glb.hit &&
                      (glb.free  ? (!valid_r && !ci.free) :
                       glb.clear ? (!used_r && !ci.clear) : first);
  // clock hand passes this entry
  assign sweep_clear = !glb.hit && !glb.free && (!glb.clear || !ci.clear);
  assign frame = frame_r;

  always_comb begin
    page_nxt  = page_r;
    frame_nxt = frame_r;
    valid_nxt = valid_r;
    dirty_nxt = dirty_r;
    used_nxt  = used_r;
    if (req.go) begin
      if (hit_sel && glb.hit) begin
        used_nxt  = 1'b1;
        dirty_nxt = dirty_r | req.wr;
      end else begin
        if (sweep_clear) used_nxt = 1'b0;
        if (victim_sel) begin
          page_nxt  = req.page;
          frame_nxt = req.frame;
          valid_nxt = 1'b1;
          used_nxt  = 1'b1;
          dirty_nxt = req.wr;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    page_r  <= page_nxt;
    frame_r <= frame_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
      dirty_r <= 1'b0;
      used_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      dirty_r <= dirty_nxt;
      used_r  <= used_nxt;
    end
  end

endmodule

### sv/tlb_lookup_clock_replace.sv
// Fully associative TLB, row of entry cells with clock replacement.
// An accepted request is held in the request register, its result in the
// result register; one request per cycle sustained while results are taken,
// set by the combinational cell-chain lookup and update. Synchronous reset
// (active low) clears valid, used and dirty bits, hit counter, result valid.
module tlb_lookup_clock_replace (
  input  logic              clk,
  input  logic              rst_n,
  tlbc_in_if.sink           in_ch,
  tlbc_out_if.source        out_ch
);

  localparam int N = tlbc_pkg::ENTRIES;

  logic              req_v_r, req_v_nxt;
  logic              req_wr_r;
  tlbc_pkg::page_t   req_page_r;
  tlbc_pkg::frame_t  req_frame_r;
  logic              proc;
  logic              accept;
  tlbc_pkg::req_t    req;
  tlbc_pkg::chain_t  chain [N+1];
  tlbc_pkg::chain_t  glb;
  logic [N-1:0]      hit_vec;
  logic [N-1:0]      vic_vec;
  tlbc_pkg::frame_t  cell_frame [N];
  tlbc_pkg::frame_t  hit_frame;
  tlbc_pkg::slot_t   slot;
  logic [N-1:0]      sel;

  logic                               out_valid_r, out_valid_nxt;
  logic [tlbc_pkg::OUT_FRAME_W-1:0]   out_frame_r;
  logic                               out_hit_r;
  logic [tlbc_pkg::OUT_SLOT_W-1:0]    out_slot_r;
  tlbc_pkg::hit_cnt_t                 hit_count_r, hit_count_nxt;

  assign proc        = req_v_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !req_v_r || proc;
  assign accept      = in_ch.valid && in_ch.ready;

  assign req.go    = proc;
  assign req.wr    = req_wr_r;
  assign req.page  = req_page_r;
  assign req.frame = req_frame_r;

  assign chain[0] = '0;
  assign glb      = chain[N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    tlbc_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .req        (req),
      .first      (i == 0),
      .ci         (chain[i]),
      .glb        (glb),
      .co         (chain[i+1]),
      .hit_sel    (hit_vec[i]),
      .victim_sel (vic_vec[i]),
      .frame      (cell_frame[i])
    );
  end

  assign sel = glb.hit ? hit_vec : vic_vec;

  always_comb begin
    slot      = '0;
    hit_frame = '0;
    for (int i = 0; i < N; i++) begin
      if (sel[i]) slot = slot | tlbc_pkg::SLOT_BITS'(i);
      if (hit_vec[i]) hit_frame = hit_frame | cell_frame[i];
    end
  end

  always_comb begin
    req_v_nxt = req_v_r;
    if (proc) req_v_nxt = 1'b0;
    if (accept) req_v_nxt = 1'b1;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (proc) out_valid_nxt = 1'b1;
    hit_count_nxt = hit_count_r;
    if (proc && glb.hit) hit_count_nxt = hit_count_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_page_r  <= tlbc_pkg::to_page(in_ch.page_number);
      req_wr_r    <= in_ch.is_write;
      req_frame_r <= tlbc_pkg::to_frame(in_ch.walked_frame);
    end
    if (proc) begin
      out_frame_r <= glb.hit ? tlbc_pkg::frame_out(hit_frame)
                             : tlbc_pkg::frame_out(req_frame_r);
      out_hit_r   <= glb.hit;
      out_slot_r  <= tlbc_pkg::slot_out(slot);
    end
    if (!rst_n) begin
      req_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
      hit_count_r <= '0;
    end else begin
      req_v_r     <= req_v_nxt;
      out_valid_r <= out_valid_nxt;
      hit_count_r <= hit_count_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.frame_number = out_frame_r;
  assign out_ch.was_hit      = out_hit_r;
  assign out_ch.slot_index   = out_slot_r;

endmodule

### sv/tlbc_checker.sv
// Port-level checks for the clock-replacement TLB, bound to the top level.
// Depends on assert_macros.svh and tlbc_pkg.
`include "assert_macros.svh"

module tlbc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [tlbc_pkg::OUT_FRAME_W-1:0] out_frame_number
);

  `ASSERT_ALWAYS(a_rst_clears_out, !rst_n |=> !out_valid, "result valid set after reset")
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_frame_number), "stalled result dropped or changed")
  `ASSERT_CLK(a_stall_only_on_out, !in_ready |-> out_valid, "input stalled with no result waiting")
  `ASSERT_CLK(a_result_follows, in_valid && in_ready |=> ##1 out_valid, "no result two cycles after a request")

endmodule

bind tlb_lookup_clock_replace tlbc_checker u_tlbc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_frame_number (out_ch.frame_number)
);
